// ----- src/assert_macros.svh -----
// Assertion macros for the RTL files of the pad address generator.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define TPAG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, disabled while reset is high
`define TPAG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- src/tpag_pkg.sv -----
// Shared types and constants of the tensor pad address generator.
// No dependencies; used by the top, CSR, front and back modules (the queue does not use it).
package tpag_pkg;

   localparam int SLOT_BITS    = 60;
   localparam int STRIDE_BITS  = 24;
   localparam int NUM_SLOT_REGS = 4;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;
   localparam int QUEUE_DEPTH  = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PAD_MODE   = 3'd0,
      CSR_RANK       = 3'd1,
      CSR_SLOT_0     = 3'd2,
      CSR_SLOT_1     = 3'd3,
      CSR_SLOT_2     = 3'd4,
      CSR_SLOT_3     = 3'd5,
      CSR_FILL_VALUE = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      PAD_CONSTANT = 2'd0,
      PAD_REFLECT  = 2'd1,
      PAD_EDGE     = 2'd2
   } pad_mode_type;

   typedef struct packed {
      logic [1:0] pad_mode;
      logic [2:0] rank;
   } csr_ctrl_type;

   typedef struct packed {
      logic fill;
      logic last;
   } item_flags_type;

endpackage

// ----- src/tensor_pad_address_generator.sv -----
// Channel | dir | beat contents
// req     | in  | tdata[0] restart (rest zero)
// rsp     | out | tdata[INDEX_BITS-1:0] source index, tuser[0] use fill, tlast wrap
// csr     | in  | csr_index register number, csr_wdata value
//
// One element per cycle while rsp_tready is high; a result passes through the queue, then the
// product and result registers. The product stage has one multiplier per slot.
// Synchronous reset clears the output index, pad mode, slots and queue, and sets rank to one.
// A two-entry queue and the back-end stages absorb rsp stalls; req_tready drops only when
// the queue is full. Configuration must be written only while no item is in flight; nothing checks it.
`include "assert_macros.svh"

module tensor_pad_address_generator #(
   parameter int MAX_RANK    = 4,
   parameter int EXTENT_BITS = 12,
   parameter int INDEX_BITS  = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [7:0]                                req_tdata,  // [0] restart
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [((INDEX_BITS + 7) / 8) * 8 - 1:0]   rsp_tdata,  // source_index
   output logic [0:0]                                rsp_tuser,  // [0] use_fill
   output logic                                      rsp_tlast,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [tpag_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  logic [tpag_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);

   localparam int COORD_W = MAX_RANK * EXTENT_BITS;
   localparam int FLAG_W  = $bits(tpag_pkg::item_flags_type);
   localparam int Q_W     = COORD_W + FLAG_W;
   localparam int TDATA_W = ((INDEX_BITS + 7) / 8) * 8;

   tpag_pkg::csr_ctrl_type     ctrl;
   logic [EXTENT_BITS-1:0]     in_ext  [MAX_RANK];
   logic [EXTENT_BITS-1:0]     out_ext [MAX_RANK];
   logic [EXTENT_BITS-1:0]     pad     [MAX_RANK];
   logic [tpag_pkg::STRIDE_BITS-1:0] stride [MAX_RANK];

   logic                       f_valid, f_ready;
   logic [COORD_W-1:0]         f_coord;
   tpag_pkg::item_flags_type   f_flags;
   logic                       q_valid, q_ready;
   logic [Q_W-1:0]             q_data;
   tpag_pkg::item_flags_type   q_flags;
   logic [INDEX_BITS-1:0]      b_index;
   tpag_pkg::item_flags_type   b_flags;
   logic                       fill_beat;
   logic                       const_mode;

   tpag_csr #(
      .MAX_RANK    (MAX_RANK),
      .EXTENT_BITS (EXTENT_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctrl      (ctrl),
      .in_ext    (in_ext),
      .out_ext   (out_ext),
      .pad       (pad),
      .stride    (stride)
   );

   tpag_front #(
      .MAX_RANK    (MAX_RANK),
      .EXTENT_BITS (EXTENT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .in_ext    (in_ext),
      .out_ext   (out_ext),
      .pad       (pad),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .restart   (req_tdata[0]),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_coord (f_coord),
      .out_flags (f_flags)
   );

   tpag_fifo #(
      .WIDTH (Q_W),
      .DEPTH (tpag_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_flags, f_coord}),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   assign q_flags = q_data[Q_W-1:COORD_W];

   tpag_back #(
      .MAX_RANK    (MAX_RANK),
      .EXTENT_BITS (EXTENT_BITS),
      .INDEX_BITS  (INDEX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .stride    (stride),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_coord  (q_data[COORD_W-1:0]),
      .in_flags  (q_flags),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_index (b_index),
      .rsp_flags (b_flags)
   );

   assign rsp_tdata    = TDATA_W'(b_index);
   assign rsp_tuser[0] = b_flags.fill;
   assign rsp_tlast    = b_flags.last;

   assign fill_beat  = rsp_tvalid && rsp_tuser[0];
   assign const_mode = ctrl.pad_mode == tpag_pkg::PAD_CONSTANT;

   // a stalled request means the queue is holding items for the back end
   `TPAG_ASSERT_IMPLY(a_stall_needs_backlog, clock, reset, !req_tready, q_valid)
   // fill is only ever raised in constant mode
   `TPAG_ASSERT_IMPLY(a_fill_constant_only, clock, reset, fill_beat, const_mode)
   // a filled element carries a zero source index
   `TPAG_ASSERT_IMPLY(a_fill_zero_index, clock, reset, fill_beat, b_index == '0)

endmodule

// ----- src/tpag_csr.sv -----
// Configuration registers of the pad address generator: mode, rank, slot descriptors.
// Depends on tpag_pkg. Slots at or beyond the stored count read as zero.
module tpag_csr #(
   parameter int MAX_RANK    = 4,
   parameter int EXTENT_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tpag_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [tpag_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output tpag_pkg::csr_ctrl_type              ctrl,
   output logic [EXTENT_BITS-1:0]              in_ext  [MAX_RANK],
   output logic [EXTENT_BITS-1:0]              out_ext [MAX_RANK],
   output logic [EXTENT_BITS-1:0]              pad     [MAX_RANK],
   output logic [tpag_pkg::STRIDE_BITS-1:0]    stride  [MAX_RANK]
);

   localparam int NSLOT  = (MAX_RANK < tpag_pkg::NUM_SLOT_REGS) ?
                           MAX_RANK : tpag_pkg::NUM_SLOT_REGS;
   localparam int FIELD_W = 3 * EXTENT_BITS + tpag_pkg::STRIDE_BITS;

   logic [1:0]                        mode_ff, mode_in;
   logic [2:0]                        rank_ff, rank_in;
   logic [tpag_pkg::SLOT_BITS-1:0]    slot_ff [NSLOT];
   logic [tpag_pkg::SLOT_BITS-1:0]    slot_in [NSLOT];
   logic [tpag_pkg::CSR_IDX_BITS-1:0] slot_sel;
   logic                              we;

   assign csr_ready = 1'b1;
   assign we        = csr_valid;
   assign slot_sel  = csr_index - tpag_pkg::CSR_IDX_BITS'(tpag_pkg::CSR_SLOT_0);

   always_comb begin
      mode_in = mode_ff;
      rank_in = rank_ff;
      for (int k = 0; k < NSLOT; k++) begin
         slot_in[k] = slot_ff[k];
      end
      if (we) begin
         case (csr_index)
            tpag_pkg::CSR_PAD_MODE: begin
               mode_in = csr_wdata[1:0];
            end
            tpag_pkg::CSR_RANK: begin
               rank_in = csr_wdata[2:0];
            end
            tpag_pkg::CSR_FILL_VALUE: begin
               // fill bits are applied downstream by the consumer; nothing kept here
            end
            default: begin
               for (int k = 0; k < NSLOT; k++) begin
                  if (slot_sel == tpag_pkg::CSR_IDX_BITS'(k)) begin
                     slot_in[k] = csr_wdata[tpag_pkg::SLOT_BITS-1:0];
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         rank_ff <= 3'd1;
         for (int k = 0; k < NSLOT; k++) begin
            slot_ff[k] <= '0;
         end
      end else begin
         mode_ff <= mode_in;
         rank_ff <= rank_in;
         for (int k = 0; k < NSLOT; k++) begin
            slot_ff[k] <= slot_in[k];
         end
      end
   end

   assign ctrl.pad_mode = mode_ff;
   assign ctrl.rank     = rank_ff;

   always_comb begin
      logic [FIELD_W-1:0] f;
      for (int s = 0; s < MAX_RANK; s++) begin
         f = '0;
         if (s < NSLOT) begin
            f = FIELD_W'(slot_ff[s]);
         end
         in_ext[s]  = f[EXTENT_BITS-1:0];
         out_ext[s] = f[2*EXTENT_BITS-1:EXTENT_BITS];
         pad[s]     = f[3*EXTENT_BITS-1:2*EXTENT_BITS];
         stride[s]  = f[FIELD_W-1:3*EXTENT_BITS];
      end
   end

endmodule

// ----- src/tpag_front.sv -----
// Front end: keeps the output index, maps each coordinate into the input, flags fill and wrap.
// Depends on tpag_pkg. Feeds the mapped coordinates into the item queue.
module tpag_front #(
   parameter int MAX_RANK    = 4,
   parameter int EXTENT_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tpag_pkg::csr_ctrl_type            ctrl,
   input  logic [EXTENT_BITS-1:0]            in_ext  [MAX_RANK],
   input  logic [EXTENT_BITS-1:0]            out_ext [MAX_RANK],
   input  logic [EXTENT_BITS-1:0]            pad     [MAX_RANK],
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              restart,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [MAX_RANK*EXTENT_BITS-1:0]   out_coord,
   output tpag_pkg::item_flags_type          out_flags
);

   localparam int RANK_W = $clog2(MAX_RANK + 1);
   localparam int SW     = EXTENT_BITS + 3;
   localparam logic signed [SW-1:0] ONE = SW'(1);
   localparam logic signed [SW-1:0] TWO = SW'(2);

   logic [EXTENT_BITS-1:0] coord_ff [MAX_RANK];
   logic [EXTENT_BITS-1:0] coord_in [MAX_RANK];
   logic [EXTENT_BITS-1:0] eff      [MAX_RANK];
   logic [MAX_RANK-1:0]    active, wrap, inc, fill_s;
   logic [RANK_W-1:0]      act_rank;
   logic                   accept;
   logic                   carry;

   assign req_ready = out_ready;
   assign out_valid = req_valid;
   assign accept    = req_valid && out_ready;

   always_comb begin
      if (ctrl.rank == '0) begin
         act_rank = RANK_W'(1);
      end else if ({1'b0, ctrl.rank} > 4'(MAX_RANK)) begin
         act_rank = RANK_W'(MAX_RANK);
      end else begin
         act_rank = RANK_W'(ctrl.rank);
      end
   end

   // coordinate mapping, one independent lane per slot
   always_comb begin
      logic signed [SW-1:0] r, t, ext_s;
      for (int s = 0; s < MAX_RANK; s++) begin
         t         = '0;
         eff[s]    = restart ? '0 : coord_ff[s];
         active[s] = RANK_W'(s) < act_rank;
         ext_s     = SW'(in_ext[s]);
         r         = SW'(eff[s]) - SW'(pad[s]);
         fill_s[s] = 1'b0;
         case (ctrl.pad_mode)
            tpag_pkg::PAD_CONSTANT: begin
               if (r[SW-1] || r >= ext_s) begin
                  fill_s[s] = 1'b1;
                  r = '0;
               end
            end
            tpag_pkg::PAD_REFLECT: begin
               if (r[SW-1]) begin
                  r = -r;
               end
               t = (ext_s <<< 1) - r - TWO;
               if (t < r) begin
                  r = t;
               end
               if (r > ext_s - ONE) begin
                  r = ext_s - ONE;
               end
               if (r[SW-1]) begin
                  r = '0;
               end
            end
            default: begin
               if (r > ext_s - ONE) begin
                  r = ext_s - ONE;
               end
               if (r[SW-1]) begin
                  r = '0;
               end
            end
         endcase
         out_coord[s*EXTENT_BITS +: EXTENT_BITS] = active[s] ? r[EXTENT_BITS-1:0] : '0;
         wrap[s] = (EXTENT_BITS+1)'(eff[s]) + (EXTENT_BITS+1)'(1)
                   >= (EXTENT_BITS+1)'(out_ext[s]);
      end
   end

   // ripple the increment from the fastest active slot toward slot 0
   always_comb begin
      carry = 1'b1;
      for (int s = MAX_RANK - 1; s >= 0; s--) begin
         inc[s] = active[s] && carry;
         if (active[s]) begin
            carry = carry && wrap[s];
         end
      end
   end

   assign out_flags.fill = |(fill_s & active);
   assign out_flags.last = carry;

   always_comb begin
      for (int s = 0; s < MAX_RANK; s++) begin
         coord_in[s] = coord_ff[s];
         if (accept) begin
            if (inc[s]) begin
               coord_in[s] = wrap[s] ? '0 : eff[s] + EXTENT_BITS'(1);
            end else begin
               coord_in[s] = eff[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < MAX_RANK; s++) begin
            coord_ff[s] <= '0;
         end
      end else begin
         for (int s = 0; s < MAX_RANK; s++) begin
            coord_ff[s] <= coord_in[s];
         end
      end
   end

endmodule

// ----- src/tpag_fifo.sv -----
// Short item queue between the front and the back of the pad address generator.
// Depends on tpag_pkg only through its users; plain register-based ring.
module tpag_fifo #(
   parameter int WIDTH = 50,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/tpag_back.sv -----
// Back end: coordinate-times-stride products, then the sum and the result register.
// Depends on tpag_pkg. Two stages with a ready chain, one item per cycle while rsp_ready is high.
module tpag_back #(
   parameter int MAX_RANK    = 4,
   parameter int EXTENT_BITS = 12,
   parameter int INDEX_BITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tpag_pkg::STRIDE_BITS-1:0]  stride [MAX_RANK],
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [MAX_RANK*EXTENT_BITS-1:0]   in_coord,
   input  tpag_pkg::item_flags_type          in_flags,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [INDEX_BITS-1:0]             rsp_index,
   output tpag_pkg::item_flags_type          rsp_flags
);

   localparam int PROD_W = EXTENT_BITS + tpag_pkg::STRIDE_BITS;

   logic                     pvalid_ff, pvalid_in;
   logic [INDEX_BITS-1:0]    prod_ff [MAX_RANK];
   logic [INDEX_BITS-1:0]    prod_in [MAX_RANK];
   tpag_pkg::item_flags_type pflags_ff;
   logic                     ovalid_ff, ovalid_in;
   logic [INDEX_BITS-1:0]    index_ff, index_in;
   tpag_pkg::item_flags_type oflags_ff;
   logic                     o_ready, p_ready, p_load, o_load;

   assign o_ready  = !ovalid_ff || rsp_ready;
   assign p_ready  = !pvalid_ff || o_ready;
   assign in_ready = p_ready;
   assign p_load   = in_valid && p_ready;
   assign o_load   = pvalid_ff && o_ready;

   always_comb begin
      logic [PROD_W-1:0] prod;
      for (int s = 0; s < MAX_RANK; s++) begin
         prod = PROD_W'(in_coord[s*EXTENT_BITS +: EXTENT_BITS]) * PROD_W'(stride[s]);
         prod_in[s] = INDEX_BITS'(prod);
      end
   end

   always_comb begin
      logic [INDEX_BITS-1:0] acc;
      acc = '0;
      for (int s = 0; s < MAX_RANK; s++) begin
         acc = acc + prod_ff[s];
      end
      index_in = pflags_ff.fill ? '0 : acc;
   end

   assign pvalid_in = p_ready ? in_valid : pvalid_ff;
   assign ovalid_in = o_ready ? pvalid_ff : ovalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= pvalid_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p_load) begin
         for (int s = 0; s < MAX_RANK; s++) begin
            prod_ff[s] <= prod_in[s];
         end
         pflags_ff <= in_flags;
      end
      if (o_load) begin
         index_ff  <= index_in;
         oflags_ff <= pflags_ff;
      end
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_index = index_ff;
   assign rsp_flags = oflags_ff;

endmodule
